// ===== hw/rtl/epd_pkg.sv =====
// Shared types and constants of the encoded polyline decoder.
package epd_pkg;

	localparam int MAX_CHUNKS  = 7;
	localparam int QUEUE_DEPTH = 4;

	localparam int CHAR_OFFSET = 63;
	localparam int CHUNK_MASK  = 'h3f;
	localparam int BITS_MASK   = 'h1f;

	localparam int LAT_LIMIT = 9000000;
	localparam int LON_LIMIT = 18000000;

	localparam int LAT_W = 25;
	localparam int LON_W = 26;

	localparam logic [0:0] REG_DELTA_MODE = 1'b0;
	localparam logic [0:0] REG_LON_FIRST  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_CHAR = 3'd1,
		ST_TRUNC    = 3'd2,
		ST_RANGE    = 3'd3,
		ST_TOO_LONG = 3'd4
	} status_t;

	typedef struct packed {
		logic delta_mode;
		logic lon_first;
	} cfg_t;

	typedef struct packed {
		logic       bad;
		logic       cont;
		logic [4:0] payload;
		logic       eos;
	} qword_t;

	typedef struct packed {
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
		status_t                 status;
		logic                    run_end;
	} res_t;

endpackage

// ===== hw/rtl/encoded_polyline_decoder.sv =====
// Top level of the encoded polyline decoder with its register port.
//
// Characters of an encoded polyline string arrive on the s_ stream, one word
// per character, with s_tlast on the last character of the string. Decoded
// points leave on the m_ stream as latitude and longitude in units of 1e-5
// degree; m_tuser carries the status and m_tlast marks the word that ends
// the string, by its end or by an error. A character that only adds a chunk,
// or completes the first value of a pair, yields no output word.
// The block takes one character per cycle while s_tready is high. A character passes
// the classifier into a four-entry queue; the back end takes it from the queue
// and loads the output register, so a result passes the queue register and the
// output register before m_tvalid rises.
// When the receiver holds m_tready low the result waits in the output
// register; the queue keeps taking characters until it is full, and then
// s_tready falls. Reset clears all string state, empties the queue and sets
// delta_mode to 1 and lon_first to 0. Register writes are meant for idle
// times between strings.
module encoded_polyline_decoder #(
	parameter int MAX_CHUNKS  = epd_pkg::MAX_CHUNKS,
	parameter int QUEUE_DEPTH = epd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic        s_tlast,  // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // [24:0] lat_e5, [50:25] lon_e5, zero padding above
	output logic [2:0]  m_tuser,  // [2:0] status
	output logic        m_tlast,  // run_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	epd_pkg::cfg_t   cfg_q;
	epd_pkg::qword_t push_word;
	epd_pkg::qword_t pop_word;
	epd_pkg::res_t   res;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_valid;
	logic [LW-1:0]   q_level;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delta_mode <= 1'b1;
			cfg_q.lon_first  <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				epd_pkg::REG_DELTA_MODE: cfg_q.delta_mode <= pwdata[0];
				epd_pkg::REG_LON_FIRST:  cfg_q.lon_first  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			epd_pkg::REG_DELTA_MODE: prdata = {31'd0, cfg_q.delta_mode};
			epd_pkg::REG_LON_FIRST:  prdata = {31'd0, cfg_q.lon_first};
			default:                 prdata = '0;
		endcase
	end

	epd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_word   (push_word)
	);

	epd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_word  (pop_word),
		.level     (q_level)
	);

	epd_back #(
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_word   (pop_word),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tdata = {5'd0, res.lon, res.lat};
	assign m_tuser = res.status;
	assign m_tlast = res.run_end;

	a_error_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != epd_pkg::ST_OK) |-> m_tlast && (m_tdata[50:0] == 51'd0))
		else $error("error word without run end or with nonzero coordinates");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= epd_pkg::ST_TOO_LONG))
		else $error("status code out of range");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && !s_tready |-> (q_level == LW'(QUEUE_DEPTH)))
		else $error("input stalled while the queue has room");

	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid && (!m_tvalid || m_tready))
		else $error("queue popped while the output word is stalled");

endmodule

// ===== hw/rtl/epd_front.sv =====
// Front end: accepts characters and classifies them into queue words.
module epd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata, // [7:0] char_code
	input  logic                s_tlast,
	input  logic                q_full,
	output logic                q_push,
	output epd_pkg::qword_t     q_word
);

	logic [7:0] chunk;
	logic       ready_q;

	// Ready is registered and gated by queue full, so it never waits on the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	assign s_tready = ready_q & ~q_full;
	assign q_push   = s_tvalid & s_tready;

	always_comb begin
		chunk           = s_tdata - 8'(epd_pkg::CHAR_OFFSET);
		q_word.bad      = (s_tdata < 8'(epd_pkg::CHAR_OFFSET)) ||
		                  (s_tdata > 8'(epd_pkg::CHAR_OFFSET + epd_pkg::CHUNK_MASK));
		q_word.cont     = chunk[5];
		q_word.payload  = chunk[4:0] & 5'(epd_pkg::BITS_MASK);
		q_word.eos      = s_tlast;
	end

endmodule

// ===== hw/rtl/epd_queue.sv =====
// Short queue of classified words between the front and back ends.
module epd_queue #(
	parameter int DEPTH = epd_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  epd_pkg::qword_t            push_word,
	output logic                       full,
	input  logic                       pop,
	output logic                       pop_valid,
	output epd_pkg::qword_t            pop_word,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH+1);

	epd_pkg::qword_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [LW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == LW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_word  = mem_q[rd_ptr_q];
	assign level     = count_q;
	assign do_push   = push & ~full;
	assign do_pop    = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/epd_back.sv =====
// Back end: assembles values and points, checks them and holds the result word.
module epd_back #(
	parameter int MAX_CHUNKS = epd_pkg::MAX_CHUNKS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  epd_pkg::cfg_t   cfg,
	input  logic            q_valid,
	input  epd_pkg::qword_t q_word,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output epd_pkg::res_t   res
);

	localparam int W  = 5 * MAX_CHUNKS;
	localparam int CW = $clog2(MAX_CHUNKS + 1);
	localparam int EW = (W > 33) ? W : 33;
	localparam logic signed [EW-1:0] SMAX = EW'(32'sh7fffffff);
	localparam logic signed [EW-1:0] SMIN = EW'(32'sh80000000);
	localparam logic signed [32:0] LAT_HI = 33'(epd_pkg::LAT_LIMIT);
	localparam logic signed [32:0] LON_HI = 33'(epd_pkg::LON_LIMIT);

	logic [W-1:0]                     acc_q;
	logic [CW-1:0]                    cnt_q;
	logic                             phase_q;
	logic signed [31:0]               hold_q;
	logic signed [epd_pkg::LAT_W-1:0] run_lat_q;
	logic signed [epd_pkg::LON_W-1:0] run_lon_q;
	logic                             aborted_q;
	logic                             out_valid_q;
	epd_pkg::res_t                    res_q;

	logic [W-1:0]       acc_new;
	logic [CW-1:0]      cnt_new;
	logic signed [W-1:0]  v_w;
	logic signed [EW-1:0] v_e;
	logic signed [31:0] v32;
	logic signed [31:0] lat_sel;
	logic signed [31:0] lon_sel;
	logic signed [32:0] lat_sum;
	logic signed [32:0] lon_sum;
	epd_pkg::status_t   status;
	logic               point;
	logic               clear;
	logic               emit;

	assign q_pop    = q_valid & (~out_valid_q | m_tready);
	assign m_tvalid = out_valid_q;
	assign res      = res_q;

	always_comb begin
		for (int k = 0; k < MAX_CHUNKS; k++) begin
			acc_new[5*k +: 5] = acc_q[5*k +: 5] |
			                    ((cnt_q == CW'(k)) ? q_word.payload : 5'd0);
		end
		cnt_new = cnt_q + 1'b1;
		v_w     = acc_new[0] ? ~{1'b0, acc_new[W-1:1]} : {1'b0, acc_new[W-1:1]};
		v_e     = EW'(v_w);
		if (v_e > SMAX) begin
			v32 = 32'sh7fffffff;
		end else if (v_e < SMIN) begin
			v32 = 32'sh80000000;
		end else begin
			v32 = v_e[31:0];
		end
		lat_sel = cfg.lon_first ? v32 : hold_q;
		lon_sel = cfg.lon_first ? hold_q : v32;
		lat_sum = 33'(lat_sel) + (cfg.delta_mode ? 33'(run_lat_q) : 33'sd0);
		lon_sum = 33'(lon_sel) + (cfg.delta_mode ? 33'(run_lon_q) : 33'sd0);

		status = epd_pkg::ST_OK;
		point  = 1'b0;
		if (q_word.bad) begin
			status = epd_pkg::ST_BAD_CHAR;
		end else if (q_word.cont) begin
			if (cnt_new >= CW'(MAX_CHUNKS)) begin
				status = epd_pkg::ST_TOO_LONG;
			end else if (q_word.eos) begin
				status = epd_pkg::ST_TRUNC;
			end
		end else if (!phase_q) begin
			if (q_word.eos) begin
				status = epd_pkg::ST_TRUNC;
			end
		end else if (lat_sum > LAT_HI || lat_sum < -LAT_HI ||
		             lon_sum > LON_HI || lon_sum < -LON_HI) begin
			status = epd_pkg::ST_RANGE;
		end else begin
			point = 1'b1;
		end
		clear = (status != epd_pkg::ST_OK) || q_word.eos;
		emit  = q_pop && !aborted_q && ((status != epd_pkg::ST_OK) || point);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			hold_q      <= '0;
			run_lat_q   <= '0;
			run_lon_q   <= '0;
			aborted_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (aborted_q) begin
					if (q_word.eos) begin
						aborted_q <= 1'b0;
					end
				end else begin
					if (clear) begin
						acc_q     <= '0;
						cnt_q     <= '0;
						phase_q   <= 1'b0;
						hold_q    <= '0;
						run_lat_q <= '0;
						run_lon_q <= '0;
						aborted_q <= (status != epd_pkg::ST_OK) && !q_word.eos;
					end else if (q_word.cont) begin
						acc_q <= acc_new;
						cnt_q <= cnt_new;
					end else begin
						acc_q   <= '0;
						cnt_q   <= '0;
						phase_q <= ~phase_q;
						if (!phase_q) begin
							hold_q <= v32;
						end else if (cfg.delta_mode) begin
							run_lat_q <= lat_sum[epd_pkg::LAT_W-1:0];
							run_lon_q <= lon_sum[epd_pkg::LON_W-1:0];
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.status <= status;
			if (point) begin
				res_q.lat     <= lat_sum[epd_pkg::LAT_W-1:0];
				res_q.lon     <= lon_sum[epd_pkg::LON_W-1:0];
				res_q.run_end <= q_word.eos;
			end else begin
				res_q.lat     <= '0;
				res_q.lon     <= '0;
				res_q.run_end <= 1'b1;
			end
		end
	end

endmodule
